### src/cwpb_pkg.sv
// cwpb_pkg: shared types and constants of the count weighted pixel blend unit
// used by the frame memory, the divider and the top level
package cwpb_pkg;

  localparam int CH_W  = 8;          // one color channel
  localparam int NUM_W = 16;         // blend numerator, below 256 * mix
  localparam int DIM_W = 13;         // wide enough for any frame dimension up to 4096
  localparam int CFG_W = 10;         // widest configuration register

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MIX_TOTAL    = 2'd2;

  localparam logic [9:0] FRAME_WIDTH_RST  = 10'd512;
  localparam logic [9:0] FRAME_HEIGHT_RST = 10'd512;
  localparam logic [7:0] MIX_TOTAL_RST    = 8'd5;

  // operation carried in in_tuser
  localparam logic FUNC_BLEND = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][CH_W-1:0]  rgb_t;
  typedef logic [2:0][NUM_W-1:0] num3_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### src/cwpb_frame_mem.sv
// cwpb_frame_mem: single write, single read frame store with registered read data
// depends on cwpb_pkg for the pixel type
module cwpb_frame_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cwpb_pkg::rgb_t   wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output cwpb_pkg::rgb_t   rd_data
);
  import cwpb_pkg::*;

  rgb_t mem [DEPTH];
  rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/cwpb_divider.sv
// cwpb_divider: three-lane restoring divider, one quotient bit per cycle
// depends on cwpb_pkg; numerators must be below 256 * den
module cwpb_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  cwpb_pkg::num3_t       num,
  input  logic [7:0]            den,
  output cwpb_pkg::rgb_t        quot,
  output cwpb_pkg::div_status_t status
);
  import cwpb_pkg::*;

  rgb_t       rem_r, rem_nxt;
  rgb_t       sh_r, sh_nxt;     // dividend bits shift out, quotient bits shift in
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [CH_W:0] trial [3];

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], sh_r[i][CH_W-1]};
    end
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = num[i][NUM_W-1:CH_W];
        sh_nxt[i]  = num[i][CH_W-1:0];
      end
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        if (trial[i] >= {1'b0, den}) begin
          rem_nxt[i] = CH_W'(trial[i] - {1'b0, den});
          sh_nxt[i]  = {sh_r[i][CH_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i][CH_W-1:0];
          sh_nxt[i]  = {sh_r[i][CH_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign quot        = sh_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

### src/count_weighted_pixel_blend_unit.sv
// count_weighted_pixel_blend_unit: top level, control sequencer and configuration
// depends on cwpb_pkg, cwpb_frame_mem and cwpb_divider
//
// Keeps a MAX_WIDTH x MAX_HEIGHT RGB888 frame store in one synchronous memory,
// pixel (x, y) at address y*MAX_WIDTH + x. After reset the unit sweeps the store
// to black, one pixel a cycle, over all MAX_WIDTH*MAX_HEIGHT addresses (262144
// at the defaults) with in_tready low; configuration writes are taken during it.
// A blend word clamps hit_count to mix_total (0 acts as 1) and writes back
// (color*kc + stored*(mix-kc))/mix per channel, returning the new pixel; a read
// word returns the stored pixel. A position outside the configured or maximum
// frame returns zeros with out_tuser set and touches nothing. One word is in
// work at a time: a blend passes the memory read and multiply, the divider
// start, the divider steps producing the quotient bits, the write back and the
// output load; a read skips the multiply and the divider, and an out-of-range
// word goes straight to the output load. The unit is back in idle as soon as
// the output register is loaded, and the next word is accepted while a result
// waits in the output register.
module count_weighted_pixel_blend_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos_x, pos_y, color_red, color_green, color_blue, hit_count
  input  logic [0:0]  in_tuser,   // func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_red, pixel_green, pixel_blue
  output logic [0:0]  out_tuser,  // out_of_range
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import cwpb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // input word fields
  logic [8:0]  in_x, in_y;
  rgb_t        in_color;
  logic [15:0] in_count;
  assign in_x        = in_tdata[8:0];
  assign in_y        = in_tdata[17:9];
  assign in_color[2] = in_tdata[25:18];
  assign in_color[1] = in_tdata[33:26];
  assign in_color[0] = in_tdata[41:34];
  assign in_count    = in_tdata[57:42];

  // configuration registers
  logic [9:0] frame_width_r, frame_height_r;
  logic [7:0] mix_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      mix_total_r    <= MIX_TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_MIX_TOTAL:    mix_total_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // zero mix total behaves as one
  logic [7:0] mix_eff;
  assign mix_eff = (mix_total_r == 8'd0) ? 8'd1 : mix_total_r;

  // bounds check and address for the word on the input
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic [7:0]    in_kc;
  assign in_range = ({1'b0, in_x} < frame_width_r) && ({1'b0, in_y} < frame_height_r) &&
                    ({4'd0, in_x} < DIM_W'(MAX_WIDTH)) && ({4'd0, in_y} < DIM_W'(MAX_HEIGHT));
  assign in_addr  = AW'(AW'(in_y) * AW'(MAX_WIDTH)) + AW'(in_x);
  // count clamped to mix total
  assign in_kc    = (in_count > {8'd0, mix_eff}) ? mix_eff : in_count[7:0];

  // sequencer and datapath registers
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  rgb_t          out_data_r, out_data_nxt;
  logic          out_oor_r, out_oor_nxt;
  logic          func_r, func_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  rgb_t          color_r, color_nxt;
  logic [7:0]    kc_r, kc_nxt;
  logic [7:0]    kb_r, kb_nxt;
  num3_t         num_r, num_nxt;
  rgb_t          res_r, res_nxt;
  logic          oor_r, oor_nxt;

  // memory and divider hookup
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr;
  rgb_t          mem_wr_data, mem_rd_data;
  logic          div_start;
  rgb_t          div_quot;
  div_status_t   div_status;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_oor_nxt   = out_oor_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    color_nxt     = color_r;
    kc_nxt        = kc_r;
    kb_nxt        = kb_r;
    num_nxt       = num_r;
    res_nxt       = res_r;
    oor_nxt       = oor_r;
    in_tready     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = addr_r;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    div_start     = 1'b0;

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // black out the store after reset
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_rd_en = in_tvalid;
        if (in_tvalid) begin
          func_nxt  = in_tuser[0];
          addr_nxt  = in_addr;
          color_nxt = in_color;
          kc_nxt    = in_kc;
          kb_nxt    = mix_eff - in_kc;
          if (in_range) begin
            oor_nxt   = 1'b0;
            state_nxt = ST_READ;
          end else begin
            oor_nxt   = 1'b1;
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        // stored pixel is on the memory output now
        if (func_r == FUNC_READ) begin
          res_nxt   = mem_rd_data;
          state_nxt = ST_DONE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num_nxt[i] = NUM_W'(NUM_W'(color_r[i]) * NUM_W'(kc_r)) +
                         NUM_W'(NUM_W'(mem_rd_data[i]) * NUM_W'(kb_r));
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // quotient never exceeds 255 since the numerator is below 256 * mix
        if (div_status.done) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = div_quot;
          res_nxt     = div_quot;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_oor_nxt   = oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_oor_r  <= out_oor_nxt;
    func_r     <= func_nxt;
    addr_r     <= addr_nxt;
    color_r    <= color_nxt;
    kc_r       <= kc_nxt;
    kb_r       <= kb_nxt;
    num_r      <= num_nxt;
    res_r      <= res_nxt;
    oor_r      <= oor_nxt;
  end

  cwpb_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (in_addr),
    .rd_data (mem_rd_data)
  );

  cwpb_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r),
    .den    (mix_eff),
    .quot   (div_quot),
    .status (div_status)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_data_r[0], out_data_r[1], out_data_r[2]};
  assign out_tuser[0] = out_oor_r;

endmodule

### src/cwpb_checker.sv
// cwpb_checker: port-level assertions for the count weighted pixel blend unit
// bound to count_weighted_pixel_blend_unit; sees its ports only
module cwpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // out-of-range results carry a black pixel
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 24'd0))
    else $error("out-of-range word with nonzero pixel");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result word changed while stalled");

  // clearing pass blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during reset clearing");

  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while busy");

endmodule

bind count_weighted_pixel_blend_unit cwpb_checker u_cwpb_checker (.*);
